@@ rtl/page_index_parser_macros.svh @@
// Assertion macros for the page index parser.
`ifndef PAGE_INDEX_PARSER_MACROS_SVH
`define PAGE_INDEX_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page_index_parser: check failed");

`define PIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page_index_parser: check failed");

`else

`define PIP_ASSERT_NOW(label, ante, cons)

`define PIP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/pip_pkg.sv @@
package pip_pkg;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_SHORT   = 3'd1,
        STATUS_MAGIC   = 3'd2,
        STATUS_VERSION = 3'd3,
        STATUS_HASH    = 3'd4,
        STATUS_TRUNC   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_HASH    = 2'd2,
        CFG_BUFLEN  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [15:0] expected_layout_hash;
        logic [19:0] buffer_length;
    } cfg_t;

    typedef struct packed {
        logic        has_entry;
        logic [15:0] page_number;
        logic [31:0] source_offset;
        logic [7:0]  style_flags;
        logic        paragraph_start;
        logic        final_result;
        status_t     status_code;
    } res_t;

endpackage

@@ rtl/pip_core.sv @@
module pip_core
    import pip_pkg::*;
#(
    parameter int HEADER_BYTES = 12,
    parameter int ENTRY_BYTES  = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    output logic       res_valid,
    output res_t       res
);

    localparam int HCW = $clog2(HEADER_BYTES);
    localparam int ECW = $clog2(ENTRY_BYTES);
    localparam int NW  = 16 + $clog2(ENTRY_BYTES + 1) + 1;

    logic           finished_reg, finished_next;
    logic           in_entries_reg, in_entries_next;
    logic [HCW-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [ECW-1:0] ent_cnt_reg, ent_cnt_next;
    logic [63:0]    header_shift_reg, header_shift_next;
    logic [15:0]    entry_total_reg, entry_total_next;
    logic [15:0]    entries_done_reg, entries_done_next;
    logic [47:0]    entry_shift_reg, entry_shift_next;

    logic [HCW-1:0] hdr_pos;
    logic           in_ent;
    logic [47:0]    entry_merge;
    logic [15:0]    done_inc;
    logic [NW-1:0]  need;
    logic           last_entry;

    assign need = NW'(HEADER_BYTES) + NW'(entry_total_reg) * NW'(ENTRY_BYTES);
    assign done_inc = entries_done_reg + 16'd1;
    assign last_entry = (done_inc >= entry_total_reg);

    always_comb
    begin
        entry_merge = entry_shift_reg;
        for (int i = 0; i < 6; i++)
        begin
            if (ent_cnt_reg == ECW'(i))
            begin
                entry_merge[8*i +: 8] = data_byte;
            end
        end
    end

    always_comb
    begin
        finished_next     = finished_reg;
        in_entries_next   = in_entries_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        ent_cnt_next      = ent_cnt_reg;
        header_shift_next = header_shift_reg;
        entry_total_next  = entry_total_reg;
        entries_done_next = entries_done_reg;
        entry_shift_next  = entry_shift_reg;
        res_valid         = 1'b0;
        res               = '0;
        hdr_pos           = first_byte ? '0 : hdr_cnt_reg;
        in_ent            = first_byte ? 1'b0 : in_entries_reg;

        if (accept)
        begin
            if (first_byte)
            begin
                finished_next     = 1'b0;
                in_entries_next   = 1'b0;
                hdr_cnt_next      = '0;
                entries_done_next = '0;
            end

            if (first_byte && (cfg.buffer_length < 20'(HEADER_BYTES)))
            begin
                res_valid          = 1'b1;
                res.final_result   = 1'b1;
                res.status_code    = STATUS_SHORT;
                finished_next      = 1'b1;
            end
            else if (first_byte || !finished_reg)
            begin
                if (!in_ent)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (hdr_pos == HCW'(i))
                        begin
                            header_shift_next[8*i +: 8] = data_byte;
                        end
                    end
                    if (hdr_pos == HCW'(8))
                    begin
                        entry_total_next[7:0] = data_byte;
                    end
                    if (hdr_pos == HCW'(9))
                    begin
                        entry_total_next[15:8] = data_byte;
                    end

                    if (hdr_pos == HCW'(HEADER_BYTES - 1))
                    begin
                        res.final_result = 1'b1;
                        res_valid        = 1'b1;
                        finished_next    = 1'b1;
                        if (header_shift_reg[31:0] != cfg.magic_word)
                        begin
                            res.status_code = STATUS_MAGIC;
                        end
                        else if (header_shift_reg[47:32] != cfg.format_version)
                        begin
                            res.status_code = STATUS_VERSION;
                        end
                        else if (header_shift_reg[63:48] != cfg.expected_layout_hash)
                        begin
                            res.status_code = STATUS_HASH;
                        end
                        else if (NW'(cfg.buffer_length) < need)
                        begin
                            res.status_code = STATUS_TRUNC;
                        end
                        else if (entry_total_reg == 16'd0)
                        begin
                            res.status_code = STATUS_OK;
                        end
                        else
                        begin
                            res_valid       = 1'b0;
                            res             = '0;
                            finished_next   = 1'b0;
                            in_entries_next = 1'b1;
                            ent_cnt_next    = '0;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_pos + HCW'(1);
                    end
                end
                else
                begin
                    entry_shift_next = entry_merge;
                    if (ent_cnt_reg == ECW'(ENTRY_BYTES - 1))
                    begin
                        ent_cnt_next        = '0;
                        entries_done_next   = done_inc;
                        res_valid           = 1'b1;
                        res.has_entry       = 1'b1;
                        res.page_number     = done_inc;
                        res.source_offset   = entry_merge[31:0];
                        res.style_flags     = entry_merge[39:32];
                        res.paragraph_start = (entry_merge[47:40] != 8'd0);
                        res.final_result    = last_entry;
                        res.status_code     = STATUS_OK;
                        if (last_entry)
                        begin
                            finished_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ent_cnt_next = ent_cnt_reg + ECW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg     <= 1'b1;
            in_entries_reg   <= 1'b0;
            hdr_cnt_reg      <= '0;
            ent_cnt_reg      <= '0;
            entry_total_reg  <= '0;
            entries_done_reg <= '0;
        end
        else
        begin
            finished_reg     <= finished_next;
            in_entries_reg   <= in_entries_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            ent_cnt_reg      <= ent_cnt_next;
            entry_total_reg  <= entry_total_next;
            entries_done_reg <= entries_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        header_shift_reg <= header_shift_next;
        entry_shift_reg  <= entry_shift_next;
    end

endmodule

@@ rtl/pip_skid.sv @@
module pip_skid
    import pip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic push;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = in_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ rtl/page_index_parser.sv @@
// Page index parser: checks and decodes a stored page-offset index, one byte per transfer.
// Slave stream carries one index byte per transfer; tuser marks the first byte of a
// buffer and restarts the parse. A 12-byte header is checked against the magic,
// version, layout hash and buffer length registers, then each 8-byte entry gives one
// result on the master stream. A failed check gives a single result with a status
// code; an empty index gives a single ok result. tlast marks the last result.
// Configuration writes (index, data) are always ready; write only while idle.
// Throughput: one byte per cycle while s_tready is high. A result is registered on the
// master side once the byte that completes it is taken (one result register).
// The master side has a result register plus one skid entry; s_tready drops only
// while the skid entry is full, so a stall on m_tready holds back the input for at
// most as long as the stall lasts once two results are waiting.
// Reset clears the configuration to zero and leaves the parser idle until a first byte;
// bytes without the first-byte flag are dropped while idle or after the last entry.
module page_index_parser
    import pip_pkg::*;
#(
    parameter int HEADER_BYTES = 12,
    parameter int ENTRY_BYTES  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tuser,     // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [15:0] page_number, [47:16] source_offset,
                                     // [55:48] style_flags, [56] paragraph_start
    output logic [3:0]  m_tuser,     // [0] has_entry, [3:1] status_code
    output logic        m_tlast,     // final_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg_reg;
    logic accept;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAGIC:   cfg_reg.magic_word           <= cfg_data;
                CFG_VERSION: cfg_reg.format_version       <= cfg_data[15:0];
                CFG_HASH:    cfg_reg.expected_layout_hash <= cfg_data[15:0];
                CFG_BUFLEN:  cfg_reg.buffer_length        <= cfg_data[19:0];
                default:     cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    pip_core #(
        .HEADER_BYTES (HEADER_BYTES),
        .ENTRY_BYTES  (ENTRY_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .res_valid  (res_valid),
        .res        (res)
    );

    pip_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'd0, out_res.paragraph_start, out_res.style_flags,
                      out_res.source_offset, out_res.page_number};
    assign m_tuser = {out_res.status_code, out_res.has_entry};
    assign m_tlast = out_res.final_result;

`include "page_index_parser_macros.svh"

    `PIP_ASSERT_NOW(a_skid_behind_out, !s_tready, m_tvalid)
    `PIP_ASSERT_NOW(a_fail_is_final, m_tvalid && (m_tuser[3:1] != STATUS_OK), m_tlast && !m_tuser[0])
    `PIP_ASSERT_NOW(a_entry_page_nonzero, m_tvalid && m_tuser[0], (m_tdata[15:0] != 16'd0) && (m_tuser[3:1] == STATUS_OK))
    `PIP_ASSERT_NEXT(a_no_result_from_nothing, !m_tvalid && !(s_tvalid && s_tready), !m_tvalid)

endmodule
